// ===== rtl/hcbd_pkg.sv =====
// Shared types, codes and helpers for the HTTP chunked body decoder.
// No dependencies; compile first.
package hcbd_pkg;

  // Character codes
  localparam logic [7:0] CH_CR = 8'd13;

  // Input operation codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  // Configuration register indexes
  localparam int unsigned     CFG_INDEX_W        = 1;
  localparam int unsigned     CFG_DATA_W         = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNKED_MODE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTENT_LENGTH = 1'd1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEN    = 3'd1,
    PH_SIZE   = 3'd2,
    PH_LF     = 3'd3,
    PH_DATA   = 3'd4,
    PH_TRAIL1 = 3'd5,
    PH_TRAIL2 = 3'd6
  } phase_t;

  // One result beat, plus a flag saying whether the item made one
  typedef struct packed {
    logic       emit;
    logic       has_byte;
    logic [7:0] body_byte;
    logic       message_done;
  } result_t;

  // Hex character to nibble; anything else reads as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h61 && c <= 8'h66)      v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    return v;
  endfunction

endpackage

// ===== rtl/hcbd_if.sv =====
// Stream and result channel interfaces for the HTTP chunked body decoder.
// Depends on nothing; compile after hcbd_pkg.
interface hcbd_stream_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface hcbd_result_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] body_byte;
  logic       message_done;

  modport source (output valid, output has_byte, output body_byte, output message_done,
                  input ready);
  modport sink   (input valid, input has_byte, input body_byte, input message_done,
                  output ready);
endinterface

// ===== rtl/hcbd_core.sv =====
// Decoder FSM: phase and byte/size counter, one input beat per cycle on accept.
// Depends on hcbd_pkg.
module hcbd_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic                                  operation,
  input  logic [7:0]                            data_byte,
  input  logic                                  chunked_mode,
  input  logic [hcbd_pkg::CFG_DATA_W-1:0]       content_length,
  output hcbd_pkg::result_t                     res
);
  import hcbd_pkg::*;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic [SIZE_BITS-1:0] len_sized;
  logic [SIZE_BITS-1:0] dec;
  logic [63:0]          len_wide;
  logic                 size_sat;

  assign len_wide  = {32'd0, content_length};
  assign len_sized = len_wide[SIZE_BITS-1:0];
  assign dec       = bytes_left - 1'b1;
  // Shifting in a nibble overflows exactly when the top nibble is non-zero
  assign size_sat  = |bytes_left[SIZE_BITS-1 -: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bytes_left <= '0;
    end else begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

  // Next state
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    if (accept) begin
      if (operation == OP_BEGIN) begin
        if (chunked_mode) begin
          phase_next      = PH_SIZE;
          bytes_left_next = '0;
        end else begin
          bytes_left_next = len_sized;
          phase_next      = (len_sized == '0) ? PH_IDLE : PH_LEN;
        end
      end else begin
        unique case (phase)
          PH_IDLE: ;
          PH_LEN: begin
            bytes_left_next = dec;
            if (dec == '0) phase_next = PH_IDLE;
          end
          PH_SIZE: begin
            if (data_byte == CH_CR) phase_next = PH_LF;
            else if (size_sat) bytes_left_next = '1;
            else bytes_left_next = {bytes_left[SIZE_BITS-5:0], hex_value(data_byte)};
          end
          PH_LF:     phase_next = (bytes_left == '0) ? PH_IDLE : PH_DATA;
          PH_DATA: begin
            bytes_left_next = dec;
            if (dec == '0) phase_next = PH_TRAIL1;
          end
          PH_TRAIL1: phase_next = PH_TRAIL2;
          PH_TRAIL2: begin
            phase_next      = PH_SIZE;
            bytes_left_next = '0;
          end
          default:   phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // Result
  always_comb begin
    res = '0;
    if (accept) begin
      if (operation == OP_BEGIN) begin
        if (!chunked_mode && len_sized == '0) begin
          res.emit         = 1'b1;
          res.message_done = 1'b1;
        end
      end else begin
        unique case (phase)
          PH_LEN: begin
            res.emit         = 1'b1;
            res.has_byte     = 1'b1;
            res.body_byte    = data_byte;
            res.message_done = (dec == '0);
          end
          PH_LF: begin
            if (bytes_left == '0) begin
              res.emit         = 1'b1;
              res.message_done = 1'b1;
            end
          end
          PH_DATA: begin
            res.emit      = 1'b1;
            res.has_byte  = 1'b1;
            res.body_byte = data_byte;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/http_chunked_body_decoder_top.sv =====
// Top level of the HTTP chunked body decoder: config registers, decoder core,
// result register. Depends on hcbd_pkg, hcbd_if and hcbd_core.
//
// Takes one beat per clock on the stream channel while ready and gives at most
// one result beat per input beat, in the cycle after it is accepted. A begin
// beat samples chunked_mode and content_length and restarts decoding; byte
// beats are then passed through (length mode) or parsed as chunk size lines,
// data and the trailing CR LF pair (chunked mode). Outside reset, the only
// thing that throttles the stream is the single result register: the stream
// is ready whenever that register is empty or being drained in the same
// cycle, so with the sink always ready the block sustains one beat per cycle.
// Configuration writes take effect at the next begin beat.
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [hcbd_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [hcbd_pkg::CFG_DATA_W-1:0]     wr_data,
  hcbd_stream_if.sink                         stream,
  hcbd_result_if.source                       result
);
  import hcbd_pkg::*;

  // Configuration registers
  logic                  chunked_mode;
  logic [CFG_DATA_W-1:0] content_length;

  // Result register
  logic       out_valid;
  logic       out_has_byte;
  logic [7:0] out_body_byte;
  logic       out_done;

  logic    accept;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode   <= 1'b0;
      content_length <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CHUNKED_MODE:   chunked_mode   <= wr_data[0];
        REG_CONTENT_LENGTH: content_length <= wr_data;
      endcase
    end
  end

  // Outside reset, the stream side stalls only while a result sits unclaimed
  assign stream.ready = !rst && (!out_valid || result.ready);
  assign accept       = stream.valid && stream.ready;

  hcbd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .operation      (stream.operation),
    .data_byte      (stream.data_byte),
    .chunked_mode   (chunked_mode),
    .content_length (content_length),
    .res            (res)
  );

  // Ready implies the register is empty or draining, so an accept just reloads it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res.emit;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.emit) begin
      out_has_byte  <= res.has_byte;
      out_body_byte <= res.body_byte;
      out_done      <= res.message_done;
    end
  end

  assign result.valid        = out_valid;
  assign result.has_byte     = out_has_byte;
  assign result.body_byte    = out_body_byte;
  assign result.message_done = out_done;

endmodule

// ===== rtl/hcbd_checker.sv =====
// Port-level checks for the HTTP chunked body decoder, bound to the top level.
// Depends on http_chunked_body_decoder_top.
module hcbd_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       has_byte,
  input logic [7:0] body_byte,
  input logic       message_done
);

  // A result beat carries a data byte, an end marker or both; never empty
  a_no_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_byte || message_done))
    else $error("result beat carries neither byte nor done");

  // No byte means a zeroed byte field
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> (body_byte == 8'd0))
    else $error("body_byte non-zero without has_byte");

  // A new result only follows an accepted input beat
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted input");

  // Stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(has_byte) &&
                                  $stable(body_byte) && $stable(message_done)))
    else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder_top hcbd_port_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (stream.valid),
  .in_ready     (stream.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .has_byte     (result.has_byte),
  .body_byte    (result.body_byte),
  .message_done (result.message_done)
);
